// ===== rtl/line_contrast_darken_filter_assert.svh =====
// ----------------------------------------------------------------------------
// line_contrast_darken_filter_assert.svh
// Assertion macros shared by the line contrast darken filter.
// ----------------------------------------------------------------------------
`ifndef LINE_CONTRAST_DARKEN_FILTER_ASSERT_SVH
`define LINE_CONTRAST_DARKEN_FILTER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define LCDF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define LCDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdf_pkg
// Types and constants shared by the line contrast darken filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdf_pkg;

   localparam int unsigned PIXEL_W = 16;
   localparam int unsigned CHAN_W  = 5;
   localparam int unsigned TRANSPARENT_BIT = 15;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd31;

   // What the back end does with a queued pixel.
   typedef enum logic [1:0] {
      JOB_PASS_UPDATE = 2'd0,   // pass unchanged, becomes the previous colour
      JOB_PASS_KEEP   = 2'd1,   // pass unchanged, previous colour untouched
      JOB_FILTER      = 2'd2    // darken against previous and next pixel
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [PIXEL_W-1:0]   pixel;
      logic [PIXEL_W-1:0]   next_pixel;
      logic                 eol;
   } job_type;

   // Up to two jobs per accepted beat; valid_b only with valid_a.
   typedef struct packed {
      logic    valid_a;
      logic    valid_b;
      job_type job_a;
      job_type job_b;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/lcdf_front.sv =====
// ----------------------------------------------------------------------------
// lcdf_front
// Accepts pixel beats, holds one pixel back and classifies released pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdf_front import lcdf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [PIXEL_W-1:0] req_pixel,
   input  wire logic               req_last_in_line,
   input  wire logic               space_two,
   output push_type                push
);

   logic [PIXEL_W-1:0] held_pixel_ff, held_pixel_in;
   logic               held_valid_ff, held_valid_in;
   logic               held_first_ff, held_first_in;
   logic               accept;
   job_type            held_job;
   job_type            last_job;

   assign req_ready = space_two;
   assign accept    = req_valid && space_two;

   always_comb begin
      held_job.pixel      = held_pixel_ff;
      held_job.next_pixel = req_pixel;
      held_job.eol        = 1'b0;
      if (held_first_ff) begin
         held_job.kind = JOB_PASS_UPDATE;
      end else if (held_pixel_ff[TRANSPARENT_BIT]) begin
         held_job.kind = JOB_PASS_KEEP;
      end else begin
         held_job.kind = JOB_FILTER;
      end

      last_job.kind       = JOB_PASS_KEEP;
      last_job.pixel      = req_pixel;
      last_job.next_pixel = req_pixel;
      last_job.eol        = 1'b1;

      // compact the two possible jobs into slot a first
      push.valid_a = accept && (held_valid_ff || req_last_in_line);
      push.valid_b = accept && held_valid_ff && req_last_in_line;
      push.job_a   = held_valid_ff ? held_job : last_job;
      push.job_b   = last_job;
   end

   always_comb begin
      held_pixel_in = held_pixel_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      if (accept) begin
         if (req_last_in_line) begin
            held_valid_in = 1'b0;
            held_first_in = 1'b0;
         end else begin
            held_pixel_in = req_pixel;
            held_valid_in = 1'b1;
            held_first_in = !held_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_pixel_ff <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
      end else begin
         held_pixel_ff <= held_pixel_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lcdf_queue.sv =====
// ----------------------------------------------------------------------------
// lcdf_queue
// Short job queue, two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdf_queue import lcdf_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire push_type push,
   input  wire logic pop,
   output job_type   head,
   output logic      head_valid,
   output logic      space_two,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   job_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_b;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH-1)) ? '0 : ptr + 1'b1;
   endfunction

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign space_two  = (count_ff <= CNT_W'(DEPTH-2));
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;
   assign wr_ptr_b   = wrap_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.valid_b) begin
         wr_ptr_in = wrap_inc(wr_ptr_b);
      end else if (push.valid_a) begin
         wr_ptr_in = wr_ptr_b;
      end
      rd_ptr_in = do_pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.valid_a) + CNT_W'(push.valid_b)
                  - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         entry_ff[wr_ptr_ff] <= push.job_a;
      end
      if (push.valid_b) begin
         entry_ff[wr_ptr_b] <= push.job_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lcdf_back.sv =====
// ----------------------------------------------------------------------------
// lcdf_back
// Darkens queued pixels against the previous output colour; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdf_back import lcdf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               full_strength,
   input  wire job_type            head,
   input  wire logic               head_valid,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [PIXEL_W-1:0]      rsp_pixel_out,
   output logic                    rsp_end_of_line
);

   logic [PIXEL_W-1:0] prev_ff, prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic               rsp_eol_ff, rsp_eol_in;
   logic [PIXEL_W-1:0] filtered;
   logic [PIXEL_W-1:0] result;

   // channel mean: sum / 3 as sum * 43 >> 7, exact for sums below 128
   function automatic logic [CHAN_W-1:0] mean3(input logic [PIXEL_W-1:0] p);
      logic [6:0]  sum;
      logic [12:0] prod;
      sum  = 7'(p[4:0]) + 7'(p[9:5]) + 7'(p[14:10]);
      prod = 13'(sum) * 13'd43;
      return prod[11:7];
   endfunction

   // c * f / 31: quotient by 32 plus one correction step
   function automatic logic [CHAN_W-1:0] scale(input logic [CHAN_W-1:0] c,
                                               input logic [CHAN_W-1:0] f);
      logic [9:0] prod;
      logic [4:0] q0;
      logic [5:0] rem;
      prod = 10'(c) * 10'(f);
      q0   = prod[9:5];
      rem  = 6'(prod[4:0]) + 6'(q0);
      return (rem >= 6'(CHAN_MAX)) ? q0 + 1'b1 : q0;
   endfunction

   function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   always_comb begin
      logic [CHAN_W-1:0] mp, mc, mn, d1, d2, d, factor;
      mp     = mean3(prev_ff);
      mc     = mean3(head.pixel);
      mn     = mean3(head.next_pixel);
      d1     = absdiff(mp, mc);
      d2     = absdiff(mn, mc);
      d      = (d1 >= d2) ? d1 : d2;
      factor = full_strength ? CHAN_MAX - d : CHAN_MAX - (d >> 1);
      if ((prev_ff == head.pixel) && (head.next_pixel == head.pixel)) begin
         filtered = head.pixel;
      end else if ((mp == mc) && (mn == mc)) begin
         filtered = head.pixel;
      end else begin
         filtered = {1'b0, scale(head.pixel[14:10], factor),
                     scale(head.pixel[9:5], factor), scale(head.pixel[4:0], factor)};
      end
   end

   always_comb begin
      case (head.kind)
         JOB_FILTER: result = filtered;
         default:    result = head.pixel;
      endcase
   end

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_eol_in   = rsp_eol_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = result;
         rsp_eol_in   = head.eol;
         if (head.kind != JOB_PASS_KEEP) begin
            prev_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_eol_ff   <= rsp_eol_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_end_of_line = rsp_eol_ff;

endmodule

`default_nettype wire

// ===== rtl/line_contrast_darken_filter.sv =====
// Flow: a pixel is written into the queue by the beat that releases it (the next
//   pixel of its line, or its own beat on a one-pixel line), then leaves through the
//   output register; the last pixel of a longer line follows its left neighbour out.
// Throughput: one pixel per cycle unless the output stalls, set by the single darken unit
//   in the back end with registered previous-colour feedback; a line of N pixels gives N beats.
// Reset: synchronous, clears held pixel, queue, previous colour, mode and output valid.
// ----------------------------------------------------------------------------
// line_contrast_darken_filter
// Streaming RGB555 scan-line darkening filter with a decoupled front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_contrast_darken_filter_assert.svh"

module line_contrast_darken_filter import lcdf_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [PIXEL_W-1:0] req_pixel,
   input  wire logic               req_last_in_line,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [PIXEL_W-1:0]      rsp_pixel_out,
   output logic                    rsp_end_of_line
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   // Mode register: 0 scales by 31 - d/2, 1 by 31 - d.
   logic full_strength_ff, full_strength_in;

   push_type         push;
   job_type          head;
   logic             head_valid;
   logic             space_two;
   logic             pop;
   logic [CNT_W-1:0] queue_count;

   assign full_strength_in = csr_write_enable ? csr_write_data : full_strength_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_strength_ff <= 1'b0;
      end else begin
         full_strength_ff <= full_strength_in;
      end
   end

   // Front: hold one pixel back so its right neighbour is known, then
   // classify it (first, transparent, filter) and push up to two jobs.
   lcdf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .req_last_in_line (req_last_in_line),
      .space_two        (space_two),
      .push             (push)
   );

   // Queue: decouples the front from output stalls; the front only takes a
   // beat while two slots are free.
   lcdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .space_two  (space_two),
      .count      (queue_count)
   );

   // Back: darken in order, track the previous output colour, register the beat.
   lcdf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .full_strength   (full_strength_ff),
      .head            (head),
      .head_valid      (head_valid),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_end_of_line (rsp_end_of_line)
   );

   // Queue never overfills, and the front only accepts with room for two jobs.
   `LCDF_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1,
      queue_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `LCDF_ASSERT_SAME(a_ready_room, clock, reset, req_ready,
      queue_count <= CNT_W'(QUEUE_DEPTH-2), "ready without room")
   // Drop the output beat once taken when nothing waits in the queue.
   `LCDF_ASSERT_NEXT(a_drain, clock, reset, !head_valid && rsp_ready, !rsp_valid,
      "stale output beat")

endmodule

`default_nettype wire
